// ===== rtl/kwm_pkg.sv =====
// shared types, codes and sizes for the k-way merge core
// used by every module under rtl but kwm_ram; depends on nothing
`timescale 1ns / 1ps

package kwm_pkg;

  // default sizes
  localparam int NUM_LISTS_DEF   = 8;
  localparam int LIST_DEPTH_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths of the stream beats
  localparam int OPCODE_W    = 2;
  localparam int LIST_ID_W   = 3;
  localparam int IN_VALUE_W  = 32;
  localparam int STATUS_W    = 3;
  localparam int OUT_VALUE_W = 32;
  localparam int SRC_W       = 3;
  localparam int POS_W       = 6;

  localparam int S_FIELDS_W = OPCODE_W + LIST_ID_W + IN_VALUE_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = STATUS_W + OUT_VALUE_W + SRC_W + POS_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

  // commands to the pointer table
  typedef struct packed {
    logic clear_all;
    logic inc_fill;
    logic inc_read;
  } ptr_cmd_t;

  // controls of the shared compare unit
  typedef struct packed {
    logic clr;
    logic cand_valid;
  } cmp_ctrl_t;

endpackage

// ===== rtl/kwm_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// depends on nothing
`timescale 1ns / 1ps

module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/kwm_ptr_table.sv =====
// per-list read pointers and fill counts, looked up at one index a cycle
// depends on kwm_pkg
`timescale 1ns / 1ps

module kwm_ptr_table #(
  parameter int NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF,
  localparam int LW = $clog2(NUM_LISTS),
  localparam int PW = $clog2(LIST_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LW-1:0]    idx,
  input  kwm_pkg::ptr_cmd_t cmd,
  output logic [PW-1:0]    rd_ptr,
  output logic [PW-1:0]    fill
);

  logic [PW-1:0] rp [NUM_LISTS];
  logic [PW-1:0] fc [NUM_LISTS];

  assign rd_ptr = rp[idx];
  assign fill   = fc[idx];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        rp[i] <= '0;
        fc[i] <= '0;
      end
    end else begin
      if (cmd.inc_fill) begin
        fc[idx] <= fc[idx] + PW'(1);
      end
      if (cmd.inc_read) begin
        rp[idx] <= rp[idx] + PW'(1);
      end
    end
  end

endmodule

// ===== rtl/kwm_cmp.sv =====
// shared signed compare unit holding the running minimum of one pop scan
// depends on kwm_pkg
`timescale 1ns / 1ps

module kwm_cmp #(
  parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF,
  localparam int LW = $clog2(NUM_LISTS),
  localparam int PW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kwm_pkg::cmp_ctrl_t     ctrl,
  input  logic [VALUE_WIDTH-1:0] cand_value,
  input  logic [LW-1:0]          cand_idx,
  input  logic [PW-1:0]          cand_pos,
  output logic                   found,
  output logic [VALUE_WIDTH-1:0] best_value,
  output logic [LW-1:0]          best_idx,
  output logic [PW-1:0]          best_pos
);

  logic take;

  // strict less-than keeps the lower list on ties, lists arrive in index order
  assign take = ctrl.cand_valid &&
                (!found || ($signed(cand_value) < $signed(best_value)));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
    if (take) begin
      best_value <= cand_value;
      best_idx   <= cand_idx;
      best_pos   <= cand_pos;
    end
  end

endmodule

// ===== rtl/k_way_sorted_merge_core.sv =====
// k-way merge core: sequencer, list store, pointer table and compare unit
// depends on kwm_pkg, kwm_ram, kwm_ptr_table, kwm_cmp
//
//   channel  dir  fields (tdata, lowest bit first)
//   s_axis   in   opcode[1:0], list_id[4:2], value[36:5]
//   m_axis   out  status[2:0], out_value[34:3], source_list[37:35], position[43:38]
//
// one item at a time: s_tready is high only while the sequencer is idle
// load, clear: an accepted item passes S_EXEC, then waits in S_OUT until the output is free for its result beat
// pop: S_EXEC, S_SCAN, S_DRAIN, S_FINISH, then S_OUT; the scan reads one list head a cycle from the
//   single read port of the list store through the shared compare unit
// a result beat holds until taken; the next item can be accepted before that
// reset empties all lists at once; the list store itself is not cleared
`timescale 1ns / 1ps

module k_way_sorted_merge_core #(
  parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode, list_id, value
  input  logic [kwm_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status, out_value, source_list, position
  output logic [kwm_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int LW = $clog2(NUM_LISTS);
  localparam int PW = $clog2(LIST_DEPTH + 1);
  localparam int SW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int AW = LW + SW;
  localparam int RAM_DEPTH = NUM_LISTS * (1 << SW);

  localparam int OPC_LO = 0;
  localparam int LID_LO = OPC_LO + kwm_pkg::OPCODE_W;
  localparam int VAL_LO = LID_LO + kwm_pkg::LIST_ID_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SCAN, S_DRAIN, S_FINISH, S_OUT
  } state_t;

  state_t state;

  // latched item
  logic [kwm_pkg::OPCODE_W-1:0]  op;
  logic [kwm_pkg::LIST_ID_W-1:0] lid;
  logic [VALUE_WIDTH-1:0]        val;

  // staged result
  logic [kwm_pkg::STATUS_W-1:0]    res_status;
  logic [kwm_pkg::OUT_VALUE_W-1:0] res_value;
  logic [kwm_pkg::SRC_W-1:0]       res_src;
  logic [kwm_pkg::POS_W-1:0]       res_pos;

  // scan pipeline
  logic [LW-1:0] scan_k;
  logic          pend_valid;
  logic [LW-1:0] pend_idx;
  logic [PW-1:0] pend_pos;

  logic signed [kwm_pkg::IN_VALUE_W-1:0] in_value;
  logic [LW-1:0]            idx;
  logic [PW-1:0]            rd_ptr, fill;
  kwm_pkg::ptr_cmd_t        pcmd;
  kwm_pkg::cmp_ctrl_t       cctl;
  logic                     lid_ok, list_full, head_ok;
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [VALUE_WIDTH-1:0]   ram_rdata;
  logic                     found;
  logic [VALUE_WIDTH-1:0]   best_value;
  logic [LW-1:0]            best_idx;
  logic [PW-1:0]            best_pos;
  logic                     out_free;

  assign in_value = s_tdata[VAL_LO +: kwm_pkg::IN_VALUE_W];
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign lid_ok    = (int'(lid) < NUM_LISTS);
  assign list_full = (fill == PW'(LIST_DEPTH));
  assign head_ok   = (rd_ptr < fill);

  always_comb begin
    idx = LW'(lid);
    case (state)
      S_SCAN:   idx = scan_k;
      S_FINISH: idx = best_idx;
      default:  idx = LW'(lid);
    endcase
  end

  always_comb begin
    pcmd      = '0;
    cctl      = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = {idx, fill[SW-1:0]};
    ram_raddr = {idx, rd_ptr[SW-1:0]};
    cctl.cand_valid = pend_valid;
    case (state)
      S_EXEC: begin
        case (op)
          kwm_pkg::OP_LOAD: begin
            if (lid_ok && !list_full) begin
              ram_we        = 1'b1;
              pcmd.inc_fill = 1'b1;
            end
          end
          kwm_pkg::OP_POP:   cctl.clr = 1'b1;
          kwm_pkg::OP_CLEAR: pcmd.clear_all = 1'b1;
          default: ;
        endcase
      end
      S_SCAN:   ram_re = head_ok;
      S_FINISH: pcmd.inc_read = found;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      // a new beat in S_OUT replaces the one taken in the same cycle
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          pend_valid <= 1'b0;
          if (s_tvalid) begin
            op    <= s_tdata[OPC_LO +: kwm_pkg::OPCODE_W];
            lid   <= s_tdata[LID_LO +: kwm_pkg::LIST_ID_W];
            val   <= VALUE_WIDTH'(in_value);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_value <= '0;
          res_src   <= '0;
          res_pos   <= '0;
          scan_k    <= '0;
          state     <= S_OUT;
          case (op)
            kwm_pkg::OP_LOAD: begin
              res_status <= (lid_ok && !list_full) ? kwm_pkg::ST_STORED
                                                   : kwm_pkg::ST_FULL;
            end
            kwm_pkg::OP_POP:   state <= S_SCAN;
            kwm_pkg::OP_CLEAR: res_status <= kwm_pkg::ST_CLEARED;
            default:           res_status <= kwm_pkg::ST_EMPTY;
          endcase
        end
        S_SCAN: begin
          // issue head read of list scan_k; its compare follows in the next cycle
          pend_valid <= head_ok;
          pend_idx   <= scan_k;
          pend_pos   <= rd_ptr;
          scan_k     <= scan_k + LW'(1);
          if (scan_k == LW'(NUM_LISTS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend_valid <= 1'b0;
          state      <= S_FINISH;
        end
        S_FINISH: begin
          if (found) begin
            res_status <= kwm_pkg::ST_DELIVERED;
            res_value  <= kwm_pkg::OUT_VALUE_W'(best_value);
            res_src    <= kwm_pkg::SRC_W'(best_idx);
            res_pos    <= kwm_pkg::POS_W'(best_pos);
          end else begin
            res_status <= kwm_pkg::ST_EMPTY;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= kwm_pkg::M_TDATA_W'({res_pos, res_src, res_value, res_status});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  kwm_ptr_table #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_ptr (
    .clk    (clk),
    .rst    (rst),
    .idx    (idx),
    .cmd    (pcmd),
    .rd_ptr (rd_ptr),
    .fill   (fill)
  );

  kwm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kwm_cmp #(
    .NUM_LISTS   (NUM_LISTS),
    .LIST_DEPTH  (LIST_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (cctl),
    .cand_value (ram_rdata),
    .cand_idx   (pend_idx),
    .cand_pos   (pend_pos),
    .found      (found),
    .best_value (best_value),
    .best_idx   (best_idx),
    .best_pos   (best_pos)
  );

endmodule

// ===== dv/k_way_sorted_merge_core_tb.sv =====
// self-checking testbench for the k-way merge core: load, pop, clear and unused-opcode beats
// with a cycle-free predictor of the list state; depends on kwm_pkg and k_way_sorted_merge_core
`timescale 1ns / 1ps

module k_way_sorted_merge_core_tb;

  localparam int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF;
  localparam int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF;
  localparam int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF;
  localparam int OPW = kwm_pkg::OPCODE_W;
  localparam int IDW = kwm_pkg::LIST_ID_W;
  localparam int INW = kwm_pkg::IN_VALUE_W;
  localparam logic [OPW-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [kwm_pkg::STATUS_W-1:0]    status;
    logic [kwm_pkg::OUT_VALUE_W-1:0] value;
    logic [kwm_pkg::SRC_W-1:0]       src;
    logic [kwm_pkg::POS_W-1:0]       pos;
  } merge_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  // opcode, list_id, value
  logic [kwm_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // status, out_value, source_list, position
  logic [kwm_pkg::M_TDATA_W-1:0] m_tdata;

  k_way_sorted_merge_core #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #4 clk = ~clk;

  // predicted list state
  logic signed [VALUE_WIDTH-1:0] list_mem [NUM_LISTS][LIST_DEPTH];
  int rd_ptr   [NUM_LISTS];
  int fill_cnt [NUM_LISTS];

  merge_result_t pending_results[$];
  int mismatch_count = 0;
  int items_sent = 0;
  int burst_left = 1;

  // receiver hold-off request, taken over by the receiver process
  int hold_seq = 0;
  int hold_len = 0;

  function automatic merge_result_t predict_merge(input logic [OPW-1:0] op,
                                                  input logic [IDW-1:0] id,
                                                  input logic [INW-1:0] val);
    merge_result_t r;
    logic found;
    int best;
    logic signed [VALUE_WIDTH-1:0] best_val;
    r = '0;
    r.status = kwm_pkg::ST_EMPTY;
    found = 1'b0;
    best = 0;
    best_val = '0;
    case (op)
      kwm_pkg::OP_LOAD: begin
        if (int'(id) >= NUM_LISTS || fill_cnt[id] >= LIST_DEPTH) begin
          r.status = kwm_pkg::ST_FULL;
        end else begin
          list_mem[id][fill_cnt[id]] = val[VALUE_WIDTH-1:0];
          fill_cnt[id]++;
          r.status = kwm_pkg::ST_STORED;
        end
      end
      kwm_pkg::OP_POP: begin
        // ties keep the lower list index
        for (int k = 0; k < NUM_LISTS; k++) begin
          if (rd_ptr[k] < fill_cnt[k]) begin
            if (!found || list_mem[k][rd_ptr[k]] < best_val) begin
              found = 1'b1;
              best = k;
              best_val = list_mem[k][rd_ptr[k]];
            end
          end
        end
        if (found) begin
          r.status = kwm_pkg::ST_DELIVERED;
          r.value  = kwm_pkg::OUT_VALUE_W'($unsigned(best_val));
          r.src    = kwm_pkg::SRC_W'(best);
          r.pos    = kwm_pkg::POS_W'(rd_ptr[best]);
          rd_ptr[best]++;
        end
      end
      kwm_pkg::OP_CLEAR: begin
        for (int k = 0; k < NUM_LISTS; k++) begin
          rd_ptr[k] = 0;
          fill_cnt[k] = 0;
        end
        r.status = kwm_pkg::ST_CLEARED;
      end
      default: r.status = kwm_pkg::ST_EMPTY;
    endcase
    return r;
  endfunction

  task automatic send_beat(input logic [OPW-1:0] op, input logic [IDW-1:0] id,
                           input logic [INW-1:0] val);
    merge_result_t exp_r;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(kwm_pkg::S_TDATA_W - kwm_pkg::S_FIELDS_W){1'b0}}, val, id, op};
    do @(posedge clk); while (!s_tready);
    exp_r = predict_merge(op, id, val);
    pending_results = {pending_results, exp_r};
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    burst_left = $urandom_range(1, 12);
  endtask

  task automatic flag_mismatch(input string what, input merge_result_t exp_r,
                               input merge_result_t got_r);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: exp sts %0d val %h src %0d pos %0d, got sts %0d val %h src %0d pos %0d",
               $realtime, what, exp_r.status, exp_r.value, exp_r.src, exp_r.pos,
               got_r.status, got_r.value, got_r.src, got_r.pos);
  endtask

  // result checker
  merge_result_t got_res, exp_res;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.status = m_tdata[2:0];
      got_res.value  = m_tdata[34:3];
      got_res.src    = m_tdata[37:35];
      got_res.pos    = m_tdata[43:38];
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result beat", '0, got_res);
      end else begin
        exp_res = pending_results.pop_front();
        if (got_res.status !== exp_res.status || got_res.value !== exp_res.value ||
            got_res.src !== exp_res.src || got_res.pos !== exp_res.pos)
          flag_mismatch("result mismatch", exp_res, got_res);
      end
    end
  end

  // receiver stall pattern, with long hold-offs on request
  int hold_seen = 0;
  int hold_cnt = 0;
  int stall_mode = 0;
  int mode_left = 0;
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_cnt = hold_len;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(30, 200);
    end else begin
      mode_left--;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic test_directed();
    send_beat(kwm_pkg::OP_CLEAR, 3'd5, 32'hFFFF_FFFF);
    send_beat(kwm_pkg::OP_POP, 3'd7, 32'hFFFF_FFFF);          // nothing loaded yet
    send_beat(OP_UNUSED, 3'd7, 32'hFFFF_FFFF);
    send_beat(OP_UNUSED, 3'd0, 32'h0000_0000);
    send_beat(kwm_pkg::OP_LOAD, 3'd0, 32'h7FFF_FFFF);
    send_beat(kwm_pkg::OP_LOAD, 3'd7, 32'h8000_0000);
    send_beat(kwm_pkg::OP_LOAD, 3'd3, 32'h0000_0000);
    send_beat(kwm_pkg::OP_LOAD, 3'd5, 32'hFFFF_FFFF);
    send_beat(kwm_pkg::OP_LOAD, 3'd7, 32'h0000_0000);
    send_beat(kwm_pkg::OP_LOAD, 3'd6, 32'h0000_0000);
    // minimum first, then equal heads resolve to the lower list
    repeat (6) send_beat(kwm_pkg::OP_POP, 3'd2, 32'h5555_AAAA);
    send_beat(kwm_pkg::OP_POP, 3'd0, 32'h0000_0000);
    send_beat(kwm_pkg::OP_LOAD, 3'd4, 32'hAAAA_AAAA);
    send_beat(kwm_pkg::OP_LOAD, 3'd4, 32'h5555_5555);
    send_beat(kwm_pkg::OP_CLEAR, 3'd0, 32'h0000_0000);
    send_beat(kwm_pkg::OP_POP, 3'd4, 32'h0000_0000);
    send_beat(kwm_pkg::OP_LOAD, 3'd1, 32'h0000_0001);
    send_beat(kwm_pkg::OP_POP, 3'd1, 32'h0000_0000);
  endtask

  task automatic test_list_full();
    logic [IDW-1:0] id;
    id = IDW'($urandom_range(0, NUM_LISTS - 1));
    send_beat(kwm_pkg::OP_CLEAR, IDW'($urandom), $urandom);
    repeat (LIST_DEPTH) send_beat(kwm_pkg::OP_LOAD, id, $urandom);
    repeat (3) send_beat(kwm_pkg::OP_LOAD, id, $urandom);      // dropped
    send_beat(kwm_pkg::OP_LOAD, id + 3'd1, $urandom);
    repeat (4) send_beat(kwm_pkg::OP_POP, IDW'($urandom), $urandom);
    send_beat(kwm_pkg::OP_LOAD, id, $urandom);                 // pops free no space
    send_beat(kwm_pkg::OP_CLEAR, IDW'($urandom), $urandom);
    send_beat(kwm_pkg::OP_LOAD, id, $urandom);
    send_beat(kwm_pkg::OP_POP, IDW'($urandom), $urandom);
  endtask

  task automatic test_backpressure();
    wait_results_drained();
    hold_len = 400;
    hold_seq++;
    burst_left = 40;
    repeat (30) begin
      if ($urandom_range(0, 1) == 0) send_beat(kwm_pkg::OP_LOAD, IDW'($urandom), $urandom);
      else send_beat(kwm_pkg::OP_POP, IDW'($urandom), $urandom);
    end
    wait_results_drained();
  endtask

  task automatic test_merge_rounds();
    int left [NUM_LISTS];
    longint next_val [NUM_LISTS];
    int total;
    int pops;
    int style;
    int k;
    while (items_sent < 1600) begin
      if ($urandom_range(0, 3) != 0) send_beat(kwm_pkg::OP_CLEAR, IDW'($urandom), $urandom);
      style = $urandom_range(0, 3);
      total = 0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        left[i] = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        case (style)
          0: next_val[i] = longint'($signed($urandom));
          1: next_val[i] = longint'($urandom_range(0, 6)) - 3;
          2: next_val[i] = -64'sd2147483648 + $urandom_range(0, 2);
          default: next_val[i] = 0;
        endcase
        total += left[i];
      end
      if ($urandom_range(0, 7) == 0) begin
        k = $urandom_range(0, NUM_LISTS - 1);
        total += LIST_DEPTH + 2 - left[k];
        left[k] = LIST_DEPTH + 2;
      end
      pops = 0;
      while (total > 0) begin
        k = $urandom_range(0, NUM_LISTS - 1);
        if (left[k] != 0) begin
          if ($urandom_range(0, 11) == 0)
            send_beat(OPW'($urandom), IDW'($urandom), $urandom);
          // style 3 loads unsorted values
          send_beat(kwm_pkg::OP_LOAD, IDW'(k), (style == 3) ? $urandom : 32'(next_val[k]));
          left[k]--;
          total--;
          pops++;
          case (style)
            0: next_val[k] += $urandom_range(0, 1 << 26);
            1: next_val[k] += $urandom_range(0, 1);
            2: next_val[k] += ($urandom_range(0, 1) == 0) ? 0 : longint'($urandom);
            default: next_val[k] = 0;
          endcase
          if (next_val[k] > 64'sd2147483647) next_val[k] = 64'sd2147483647;
        end
      end
      if ($urandom_range(0, 5) == 0) wait_results_drained();
      pops = pops + $urandom_range(0, 4) - 2;
      repeat ((pops < 0) ? 0 : pops) begin
        if ($urandom_range(0, 11) == 0) send_beat(OPW'($urandom), IDW'($urandom), $urandom);
        send_beat(kwm_pkg::OP_POP, IDW'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    for (int k = 0; k < NUM_LISTS; k++) begin
      rd_ptr[k] = 0;
      fill_cnt[k] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_list_full();
    test_backpressure();
    test_merge_rounds();
    wait_results_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/kwm_ptr_table.sv
rtl/kwm_cmp.sv
rtl/k_way_sorted_merge_core.sv
dv/k_way_sorted_merge_core_tb.sv
